// ===== rtl/bmp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmp_pkg
// Shared types, constants and saturating helpers of the Boris momentum push.
// ----------------------------------------------------------------------------
package bmp_pkg;

	// Word format of every field and intermediate value.
	localparam int WORD_BITS = 48;
	// Operand halves used by the split multiplier.
	localparam int LO_BITS   = 32;
	localparam int HI_BITS   = WORD_BITS - LO_BITS;
	// Register stages inside one fixed-point multiplier.
	localparam int MUL_LAT   = 4;

	typedef logic [WORD_BITS-1:0] word_t;
	typedef word_t [2:0] vec3_t;

	localparam word_t WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
	localparam word_t WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

	// One input transfer.
	typedef struct packed {
		word_t momentum_x;
		word_t momentum_y;
		word_t momentum_z;
		word_t electric_x;
		word_t electric_y;
		word_t electric_z;
		word_t magnetic_x;
		word_t magnetic_y;
		word_t magnetic_z;
	} item_t;

	// One result transfer.
	typedef struct packed {
		word_t new_momentum_x;
		word_t new_momentum_y;
		word_t new_momentum_z;
		logic  saturated;
	} result_t;

	// Saturating operation result: clamp flag and value.
	typedef struct packed {
		logic  sat;
		word_t val;
	} sres_t;

	// Context carried down the main pipeline.
	typedef struct packed {
		vec3_t p;
		vec3_t pt;
		vec3_t bf;
		vec3_t t;
		vec3_t cr;
		vec3_t sm;
		word_t s;
		word_t dot;
		word_t x;
		word_t y;
		logic  sat;
	} ctx_t;

	// Two's complement add that clamps to the word range.
	function automatic sres_t sat_add(word_t a, word_t b);
		logic [WORD_BITS:0] sum;
		sres_t r;
		sum = {a[WORD_BITS-1], a} + {b[WORD_BITS-1], b};
		if (sum[WORD_BITS] != sum[WORD_BITS-1]) begin
			r.sat = 1'b1;
			r.val = sum[WORD_BITS] ? WORD_MIN : WORD_MAX;
		end else begin
			r.sat = 1'b0;
			r.val = sum[WORD_BITS-1:0];
		end
		return r;
	endfunction

	// Two's complement subtract that clamps to the word range.
	function automatic sres_t sat_sub(word_t a, word_t b);
		logic [WORD_BITS:0] dif;
		sres_t r;
		dif = {a[WORD_BITS-1], a} - {b[WORD_BITS-1], b};
		if (dif[WORD_BITS] != dif[WORD_BITS-1]) begin
			r.sat = 1'b1;
			r.val = dif[WORD_BITS] ? WORD_MIN : WORD_MAX;
		end else begin
			r.sat = 1'b0;
			r.val = dif[WORD_BITS-1:0];
		end
		return r;
	endfunction

endpackage

// ===== rtl/bmp_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmp_mul
// Pipelined fixed-point multiply: round to nearest, ties away from zero,
// then saturate to the word. Four register stages.
// ----------------------------------------------------------------------------
module bmp_mul #(
	parameter int FRACTION_BITS = 24
) (
	input  logic          clk,
	input  logic          en,
	input  bmp_pkg::word_t a,
	input  bmp_pkg::word_t b,
	output bmp_pkg::word_t y,
	output logic          sat
);
	import bmp_pkg::*;

	localparam int PW = 2 * WORD_BITS;
	localparam int QW = PW - FRACTION_BITS;
	localparam logic [QW-1:0] LIM_POS = QW'(WORD_MAX);
	localparam logic [QW-1:0] LIM_NEG = QW'(WORD_MAX) + QW'(1);

	logic                  neg_s1, neg_s2, neg_s3;
	word_t                 ma_s1, mb_s1;
	logic [2*LO_BITS-1:0]  ll_s2;
	logic [PW-1:0]         lh_s2, hl_s2, hh_s2;
	logic [PW-1:0]         prod_s3;
	logic [QW-1:0]         rq;
	logic [QW-1:0]         lim;
	word_t                 y_n;
	logic                  sat_n;

	// Sign and magnitudes of the operands.
	always_ff @(posedge clk) begin
		if (en) begin
			neg_s1 <= a[WORD_BITS-1] ^ b[WORD_BITS-1];
			ma_s1  <= a[WORD_BITS-1] ? -a : a;
			mb_s1  <= b[WORD_BITS-1] ? -b : b;
		end
	end

	// Four partial products of the split operands.
	always_ff @(posedge clk) begin
		if (en) begin
			neg_s2 <= neg_s1;
			ll_s2  <= (2*LO_BITS)'(ma_s1[LO_BITS-1:0]) * (2*LO_BITS)'(mb_s1[LO_BITS-1:0]);
			lh_s2  <= PW'(ma_s1[LO_BITS-1:0]) * PW'(mb_s1[WORD_BITS-1:LO_BITS]);
			hl_s2  <= PW'(ma_s1[WORD_BITS-1:LO_BITS]) * PW'(mb_s1[LO_BITS-1:0]);
			hh_s2  <= PW'(ma_s1[WORD_BITS-1:LO_BITS]) * PW'(mb_s1[WORD_BITS-1:LO_BITS]);
		end
	end

	// Full product plus the rounding half.
	always_ff @(posedge clk) begin
		if (en) begin
			neg_s3  <= neg_s2;
			prod_s3 <= PW'(ll_s2) + (lh_s2 << LO_BITS) + (hl_s2 << LO_BITS)
				+ (hh_s2 << (2*LO_BITS)) + (PW'(1) << (FRACTION_BITS-1));
		end
	end

	// Drop the fraction, clamp and restore the sign.
	always_comb begin
		rq  = prod_s3[PW-1:FRACTION_BITS];
		lim = neg_s3 ? LIM_NEG : LIM_POS;
		if (rq > lim) begin
			sat_n = 1'b1;
			y_n   = neg_s3 ? WORD_MIN : WORD_MAX;
		end else begin
			sat_n = 1'b0;
			y_n   = neg_s3 ? -rq[WORD_BITS-1:0] : rq[WORD_BITS-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			y   <= y_n;
			sat <= sat_n;
		end
	end

endmodule

// ===== rtl/bmp_rsqrt.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmp_rsqrt
// Pipelined reciprocal square root, one result bit per stage:
// r = floor(2^F / sqrt(s / 2^F)), and 1.0 when s is at most 1.0.
// ----------------------------------------------------------------------------
module bmp_rsqrt #(
	parameter int FRACTION_BITS = 24
) (
	input  logic          clk,
	input  logic          en,
	input  bmp_pkg::word_t s,
	output bmp_pkg::word_t r
);
	import bmp_pkg::*;

	localparam int NS = FRACTION_BITS + 1;
	localparam int AW = 2 * FRACTION_BITS + WORD_BITS + 1;
	localparam int BW = FRACTION_BITS + WORD_BITS;
	localparam logic [AW-1:0] THRESH = AW'(1) << (3 * FRACTION_BITS);
	localparam word_t ONE = WORD_BITS'(1) << FRACTION_BITS;

	// Per stage: operand, r^2*s, r*s, partial root, small-operand flag.
	word_t                    s_s    [NS];
	logic [AW-1:0]            acc_s  [NS];
	logic [BW-1:0]            rs_s   [NS];
	logic [FRACTION_BITS-1:0] root_s [NS];
	logic                     spec_s [NS];

	logic [AW-1:0]            acc_n  [NS];
	logic [BW-1:0]            rs_n   [NS];
	logic [FRACTION_BITS-1:0] root_n [NS];

	// Trial of the next bit: (r + 2^k)^2 s = r^2 s + 2^(k+1) r s + 2^(2k) s.
	always_comb begin
		logic [AW-1:0] cand;
		acc_n[0]  = '0;
		rs_n[0]   = '0;
		root_n[0] = '0;
		for (int j = 1; j < NS; j++) begin
			cand = acc_s[j-1] + (AW'(rs_s[j-1]) << (FRACTION_BITS - j + 1))
				+ (AW'(s_s[j-1]) << (2 * (FRACTION_BITS - j)));
			if (cand <= THRESH) begin
				acc_n[j]  = cand;
				rs_n[j]   = rs_s[j-1] + (BW'(s_s[j-1]) << (FRACTION_BITS - j));
				root_n[j] = root_s[j-1] | (FRACTION_BITS'(1) << (FRACTION_BITS - j));
			end else begin
				acc_n[j]  = acc_s[j-1];
				rs_n[j]   = rs_s[j-1];
				root_n[j] = root_s[j-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			s_s[0]    <= s;
			acc_s[0]  <= acc_n[0];
			rs_s[0]   <= rs_n[0];
			root_s[0] <= root_n[0];
			spec_s[0] <= (s <= ONE);
			for (int j = 1; j < NS; j++) begin
				s_s[j]    <= s_s[j-1];
				acc_s[j]  <= acc_n[j];
				rs_s[j]   <= rs_n[j];
				root_s[j] <= root_n[j];
				spec_s[j] <= spec_s[j-1];
			end
		end
	end

	assign r = spec_s[NS-1] ? ONE : WORD_BITS'(root_s[NS-1]);

endmodule

// ===== rtl/bmp_recip.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmp_recip
// Pipelined restoring divider for the reciprocal c = floor(2^(2F) / d),
// one quotient bit per stage; 1.0 when d is at most 1.0.
// ----------------------------------------------------------------------------
module bmp_recip #(
	parameter int FRACTION_BITS = 24
) (
	input  logic          clk,
	input  logic          en,
	input  bmp_pkg::word_t d,
	output bmp_pkg::word_t c
);
	import bmp_pkg::*;

	localparam int NS = FRACTION_BITS + 1;
	localparam int RW = WORD_BITS + FRACTION_BITS + 1;
	localparam logic [RW-1:0] NUMER = RW'(1) << (2 * FRACTION_BITS);
	localparam word_t ONE = WORD_BITS'(1) << FRACTION_BITS;

	word_t                    d_s    [NS];
	logic [RW-1:0]            rem_s  [NS];
	logic [FRACTION_BITS-1:0] quo_s  [NS];
	logic                     spec_s [NS];

	logic [RW-1:0]            rem_n  [NS];
	logic [FRACTION_BITS-1:0] quo_n  [NS];

	// One trial subtraction of the shifted divisor per stage.
	always_comb begin
		logic [RW-1:0] sh;
		rem_n[0] = NUMER;
		quo_n[0] = '0;
		for (int j = 1; j < NS; j++) begin
			sh = RW'(d_s[j-1]) << (FRACTION_BITS - j);
			if (rem_s[j-1] >= sh) begin
				rem_n[j] = rem_s[j-1] - sh;
				quo_n[j] = quo_s[j-1] | (FRACTION_BITS'(1) << (FRACTION_BITS - j));
			end else begin
				rem_n[j] = rem_s[j-1];
				quo_n[j] = quo_s[j-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_s[0]    <= d;
			rem_s[0]  <= rem_n[0];
			quo_s[0]  <= quo_n[0];
			spec_s[0] <= (d <= ONE);
			for (int j = 1; j < NS; j++) begin
				d_s[j]    <= d_s[j-1];
				rem_s[j]  <= rem_n[j];
				quo_s[j]  <= quo_n[j];
				spec_s[j] <= spec_s[j-1];
			end
		end
	end

	assign c = spec_s[NS-1] ? ONE : WORD_BITS'(quo_s[NS-1]);

endmodule

// ===== rtl/boris_momentum_push.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// boris_momentum_push
// Relativistic Boris momentum rotation for one particle per transfer.
// ----------------------------------------------------------------------------
// The block takes one particle (momentum, E and B in signed Q format) per
// clock and returns the rotated momentum through a pipeline built from two
// bit-per-stage units (reciprocal square root and reciprocal) of
// FRACTION_BITS + 1 stages each, five chained four-stage multipliers and nine
// single-stage add and register steps. A new particle enters every cycle;
// when a result is held by result_stall the whole pipeline holds, and
// item_stall rises only while the last stage is full and stalled.
// The half step coefficient sits at byte address 0 of the register port and
// must be written only while no particle is in flight.
module boris_momentum_push #(
	parameter int FRACTION_BITS = 24
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_stall,
	input  bmp_pkg::item_t   item,
	output logic             result_valid,
	input  logic             result_stall,
	output bmp_pkg::result_t result,
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [3:0]       paddr,
	input  logic [63:0]      pwdata,
	output logic [63:0]      prdata,
	output logic             pready
);
	import bmp_pkg::*;

	localparam word_t ONE = WORD_BITS'(1) << FRACTION_BITS;
	localparam logic ADDR_HALF_STEP = 1'b0;

	// Stage positions of the main pipeline.
	localparam int RLAT = FRACTION_BITS + 1;
	localparam int KA   = MUL_LAT;
	localparam int KS   = KA + 3;
	localparam int K1   = KS + RLAT;
	localparam int K2   = K1 + MUL_LAT;
	localparam int K3   = K2 + MUL_LAT;
	localparam int KT   = K3 + 1;
	localparam int K4   = KT + MUL_LAT;
	localparam int K5   = K4 + 3;
	localparam int K6   = K5 + RLAT;
	localparam int K7   = K6 + MUL_LAT;
	localparam int N    = K7 + 2;

	// Multiplier slots.
	localparam int M_HE  = 0;
	localparam int M_PP  = 3;
	localparam int M_IG  = 6;
	localparam int M_T   = 7;
	localparam int M_TT  = 10;
	localparam int M_CR  = 13;
	localparam int M_DOT = 19;
	localparam int M_DT  = 22;
	localparam int M_PN  = 25;
	localparam int NMUL  = 28;

	word_t h_q;
	logic  adv;
	logic  [N:1] vld_s;
	ctx_t  ctx_s [1:N];
	ctx_t  nxt   [1:N];
	vec3_t in_p, in_e, in_b;
	word_t ma [NMUL];
	word_t mb [NMUL];
	word_t mr [NMUL];
	logic  ms [NMUL];
	word_t root, recip;

	// Register port: single coefficient register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h_q <= '0;
		end else if (psel && penable && pwrite && paddr[3] == ADDR_HALF_STEP) begin
			h_q <= pwdata[WORD_BITS-1:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr[3] == ADDR_HALF_STEP) ?
		{{(64-WORD_BITS){h_q[WORD_BITS-1]}}, h_q} : 64'd0;

	// Pipeline advances unless a finished result is held.
	assign adv          = !vld_s[N] || !result_stall;
	assign item_stall   = !adv;
	assign result_valid = vld_s[N];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[N-1:1], item_valid};
		end
	end

	assign in_p = {item.momentum_z, item.momentum_y, item.momentum_x};
	assign in_e = {item.electric_z, item.electric_y, item.electric_x};
	assign in_b = {item.magnetic_z, item.magnetic_y, item.magnetic_x};

	// Multiplier operands, each taken from the stage that feeds it.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			ma[M_HE+i]  = h_q;
			mb[M_HE+i]  = in_e[i];
			ma[M_PP+i]  = in_p[i];
			mb[M_PP+i]  = in_p[i];
			ma[M_T+i]   = mr[M_IG];
			mb[M_T+i]   = ctx_s[K2].bf[i];
			ma[M_TT+i]  = ctx_s[KT].t[i];
			mb[M_TT+i]  = ctx_s[KT].t[i];
			ma[M_DOT+i] = ctx_s[KT].pt[i];
			mb[M_DOT+i] = ctx_s[KT].t[i];
			ma[M_DT+i]  = ctx_s[K5].dot;
			mb[M_DT+i]  = ctx_s[K5].t[i];
			ma[M_PN+i]  = recip;
			mb[M_PN+i]  = ctx_s[K6].sm[i];
		end
		ma[M_IG]   = h_q;
		mb[M_IG]   = root;
		ma[M_CR]   = ctx_s[KT].pt[1];
		mb[M_CR]   = ctx_s[KT].t[2];
		ma[M_CR+1] = ctx_s[KT].pt[2];
		mb[M_CR+1] = ctx_s[KT].t[1];
		ma[M_CR+2] = ctx_s[KT].pt[2];
		mb[M_CR+2] = ctx_s[KT].t[0];
		ma[M_CR+3] = ctx_s[KT].pt[0];
		mb[M_CR+3] = ctx_s[KT].t[2];
		ma[M_CR+4] = ctx_s[KT].pt[0];
		mb[M_CR+4] = ctx_s[KT].t[1];
		ma[M_CR+5] = ctx_s[KT].pt[1];
		mb[M_CR+5] = ctx_s[KT].t[0];
	end

	for (genvar g = 0; g < NMUL; g++) begin : g_mul
		bmp_mul #(.FRACTION_BITS(FRACTION_BITS)) u_mul (
			.clk (clk),
			.en  (adv),
			.a   (ma[g]),
			.b   (mb[g]),
			.y   (mr[g]),
			.sat (ms[g])
		);
	end

	bmp_rsqrt #(.FRACTION_BITS(FRACTION_BITS)) u_rsqrt (
		.clk (clk),
		.en  (adv),
		.s   (ctx_s[KS].s),
		.r   (root)
	);

	bmp_recip #(.FRACTION_BITS(FRACTION_BITS)) u_recip (
		.clk (clk),
		.en  (adv),
		.d   (ctx_s[K5].s),
		.c   (recip)
	);

	// Next context of every stage: a copy, with the adds of that stage.
	always_comb begin
		sres_t r;
		nxt[1]    = '0;
		nxt[1].p  = in_p;
		nxt[1].bf = in_b;
		for (int k = 1; k < N; k++) begin
			nxt[k+1] = ctx_s[k];
		end

		// Kicked momentum and the start of 1 + |p|^2.
		for (int i = 0; i < 3; i++) begin
			r = sat_add(ctx_s[KA].p[i], mr[M_HE+i]);
			nxt[KA+1].pt[i] = r.val;
			nxt[KA+1].sat   = nxt[KA+1].sat | r.sat | ms[M_HE+i] | ms[M_PP+i];
		end
		r = sat_add(ONE, mr[M_PP]);
		nxt[KA+1].s   = r.val;
		nxt[KA+1].sat = nxt[KA+1].sat | r.sat;
		nxt[KA+1].x   = mr[M_PP+1];
		nxt[KA+1].y   = mr[M_PP+2];

		r = sat_add(ctx_s[KA+1].s, ctx_s[KA+1].x);
		nxt[KA+2].s   = r.val;
		nxt[KA+2].sat = ctx_s[KA+1].sat | r.sat;

		r = sat_add(ctx_s[KA+2].s, ctx_s[KA+2].y);
		nxt[KA+3].s   = r.val;
		nxt[KA+3].sat = ctx_s[KA+2].sat | r.sat;

		// Scaled inverse gamma, then the rotation vector t.
		nxt[K2+1].sat = ctx_s[K2].sat | ms[M_IG];
		for (int i = 0; i < 3; i++) begin
			nxt[K3+1].t[i] = mr[M_T+i];
		end
		nxt[K3+1].sat = ctx_s[K3].sat | ms[M_T] | ms[M_T+1] | ms[M_T+2];

		// |t|^2, cross product and dot product, first level.
		nxt[K4+1].sat = ctx_s[K4].sat;
		for (int i = M_TT; i < M_DT; i++) begin
			nxt[K4+1].sat = nxt[K4+1].sat | ms[i];
		end
		r = sat_add(mr[M_TT], mr[M_TT+1]);
		nxt[K4+1].s   = r.val;
		nxt[K4+1].sat = nxt[K4+1].sat | r.sat;
		nxt[K4+1].x   = mr[M_TT+2];
		for (int i = 0; i < 3; i++) begin
			r = sat_sub(mr[M_CR+2*i], mr[M_CR+2*i+1]);
			nxt[K4+1].cr[i] = r.val;
			nxt[K4+1].sat   = nxt[K4+1].sat | r.sat;
		end
		r = sat_add(mr[M_DOT], mr[M_DOT+1]);
		nxt[K4+1].dot = r.val;
		nxt[K4+1].sat = nxt[K4+1].sat | r.sat;
		nxt[K4+1].y   = mr[M_DOT+2];

		// Second level of the sums.
		r = sat_add(ctx_s[K4+1].s, ctx_s[K4+1].x);
		nxt[K4+2].s   = r.val;
		nxt[K4+2].sat = ctx_s[K4+1].sat | r.sat;
		r = sat_add(ctx_s[K4+1].dot, ctx_s[K4+1].y);
		nxt[K4+2].dot = r.val;
		nxt[K4+2].sat = nxt[K4+2].sat | r.sat;

		// Divisor 1 + |t|^2 and pt + pt x t.
		r = sat_add(ONE, ctx_s[K4+2].s);
		nxt[K4+3].s   = r.val;
		nxt[K4+3].sat = ctx_s[K4+2].sat | r.sat;
		for (int i = 0; i < 3; i++) begin
			r = sat_add(ctx_s[K4+2].pt[i], ctx_s[K4+2].cr[i]);
			nxt[K4+3].sm[i] = r.val;
			nxt[K4+3].sat   = nxt[K4+3].sat | r.sat;
		end

		// Add (pt . t) t while the reciprocal is in progress.
		nxt[K5+MUL_LAT+1].sat = ctx_s[K5+MUL_LAT].sat;
		for (int i = 0; i < 3; i++) begin
			r = sat_add(ctx_s[K5+MUL_LAT].sm[i], mr[M_DT+i]);
			nxt[K5+MUL_LAT+1].sm[i] = r.val;
			nxt[K5+MUL_LAT+1].sat   = nxt[K5+MUL_LAT+1].sat | r.sat | ms[M_DT+i];
		end

		// Double the scaled sum, then subtract the old momentum.
		nxt[K7+1].sat = ctx_s[K7].sat;
		for (int i = 0; i < 3; i++) begin
			r = sat_add(mr[M_PN+i], mr[M_PN+i]);
			nxt[K7+1].sm[i] = r.val;
			nxt[K7+1].sat   = nxt[K7+1].sat | r.sat | ms[M_PN+i];
		end
		nxt[K7+2].sat = ctx_s[K7+1].sat;
		for (int i = 0; i < 3; i++) begin
			r = sat_sub(ctx_s[K7+1].sm[i], ctx_s[K7+1].p[i]);
			nxt[K7+2].sm[i] = r.val;
			nxt[K7+2].sat   = nxt[K7+2].sat | r.sat;
		end
	end

	// Main pipeline registers.
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 1; k <= N; k++) begin
				ctx_s[k] <= nxt[k];
			end
		end
	end

	// Result transfer.
	always_comb begin
		result.new_momentum_x = ctx_s[N].sm[0];
		result.new_momentum_y = ctx_s[N].sm[1];
		result.new_momentum_z = ctx_s[N].sm[2];
		result.saturated      = ctx_s[N].sat;
	end

endmodule

// ===== tb/boris_momentum_push_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// boris_momentum_push_test
// Self-checking bench for the Boris momentum push. A directed table and
// random particles are sent under several half step coefficients. Each result
// is checked against a typed value or a fixed-point predictor; both sides stall.
// ----------------------------------------------------------------------------
module boris_momentum_push_test;
	import bmp_pkg::*;

	localparam int FRAC = 24;
	localparam longint WMAX = (64'sd1 <<< 47) - 1;
	localparam longint WMIN = -(64'sd1 <<< 47);
	localparam longint ONE = 64'sd1 <<< FRAC;
	localparam longint CYCLE_LIMIT = 400000;
	localparam logic [3:0] ADDR_HALF_STEP = 4'd0;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_stall;
	item_t item = '0;
	logic result_valid;
	logic result_stall = 1'b1;
	result_t result;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [3:0] paddr = '0;
	logic [63:0] pwdata = '0;
	logic [63:0] prdata;
	logic pready;

	boris_momentum_push u_top (.*);

	// Clock with a 12 ns period.
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	longint cycles = 0;
	int errors = 0;
	int pushed = 0, checked = 0, clamped = 0;
	longint coef = 0;
	bit clamp_hit;
	bit long_hold = 0;
	bit quiet_rx = 0;
	result_t pending_momenta[$];

	// Watchdog on the cycle count.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// Saturating arithmetic of the predictor; clamps set clamp_hit.
	function automatic longint clip(longint v);
		if (v > WMAX) begin clamp_hit = 1; return WMAX; end
		if (v < WMIN) begin clamp_hit = 1; return WMIN; end
		return v;
	endfunction

	function automatic longint qmul(longint a, longint b);
		logic [127:0] pr;
		logic [127:0] ma, mb, lim;
		bit neg;
		neg = (a < 0) != (b < 0);
		ma = (a < 0) ? 128'(-a) : 128'(a);
		mb = (b < 0) ? 128'(-b) : 128'(b);
		pr = ((ma * mb) + (128'd1 << (FRAC - 1))) >> FRAC;
		lim = neg ? 128'(WMAX) + 1 : 128'(WMAX);
		if (pr > lim) begin
			clamp_hit = 1;
			return neg ? WMIN : WMAX;
		end
		return neg ? -longint'(pr) : longint'(pr);
	endfunction

	// floor(2^F / sqrt(s / 2^F)), found one bit at a time.
	function automatic longint inv_sqrt(longint s);
		logic [127:0] cand, r;
		if (s <= ONE) return ONE;
		r = 0;
		for (int b = FRAC - 1; b >= 0; b--) begin
			cand = r | (128'd1 << b);
			if (cand * cand * 128'(s) <= (128'd1 << (3 * FRAC))) r = cand;
		end
		return longint'(r);
	endfunction

	function automatic longint inv(longint d);
		if (d <= ONE) return ONE;
		return longint'((128'd1 << (2 * FRAC)) / 128'(d));
	endfunction

	// Expected rotated momentum of one particle.
	function automatic result_t boris_rotate(item_t x);
		longint p[3], e[3], bf[3], pt[3], t[3], cr[3], res[3];
		longint s, ig, tt, c, dot, sm, pn;
		result_t r;
		clamp_hit = 0;
		p[0] = longint'($signed(x.momentum_x));
		p[1] = longint'($signed(x.momentum_y));
		p[2] = longint'($signed(x.momentum_z));
		e[0] = longint'($signed(x.electric_x));
		e[1] = longint'($signed(x.electric_y));
		e[2] = longint'($signed(x.electric_z));
		bf[0] = longint'($signed(x.magnetic_x));
		bf[1] = longint'($signed(x.magnetic_y));
		bf[2] = longint'($signed(x.magnetic_z));
		for (int i = 0; i < 3; i++) pt[i] = clip(p[i] + qmul(coef, e[i]));
		s = ONE;
		for (int i = 0; i < 3; i++) s = clip(s + qmul(p[i], p[i]));
		ig = qmul(coef, inv_sqrt(s));
		for (int i = 0; i < 3; i++) t[i] = qmul(ig, bf[i]);
		tt = qmul(t[0], t[0]);
		tt = clip(tt + qmul(t[1], t[1]));
		tt = clip(tt + qmul(t[2], t[2]));
		c = inv(clip(ONE + tt));
		cr[0] = clip(qmul(pt[1], t[2]) - qmul(pt[2], t[1]));
		cr[1] = clip(qmul(pt[2], t[0]) - qmul(pt[0], t[2]));
		cr[2] = clip(qmul(pt[0], t[1]) - qmul(pt[1], t[0]));
		dot = qmul(pt[0], t[0]);
		dot = clip(dot + qmul(pt[1], t[1]));
		dot = clip(dot + qmul(pt[2], t[2]));
		for (int i = 0; i < 3; i++) begin
			sm = clip(clip(pt[i] + cr[i]) + qmul(dot, t[i]));
			pn = qmul(c, sm);
			res[i] = clip(clip(pn + pn) - p[i]);
		end
		r.new_momentum_x = word_t'(res[0]);
		r.new_momentum_y = word_t'(res[1]);
		r.new_momentum_z = word_t'(res[2]);
		r.saturated = clamp_hit;
		return r;
	endfunction

	task automatic report(string field, logic [47:0] got, logic [47:0] want);
		errors++;
		$display("mismatch on result %0d, %s: got %h, expected %h", checked, field, got, want);
	endtask

	// Check each result transfer against the oldest expectation.
	always @(posedge clk) begin
		result_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (pending_momenta.size() == 0) begin
				errors++;
				$display("unexpected result transfer");
			end else begin
				want = pending_momenta.pop_front();
				if (result.new_momentum_x !== want.new_momentum_x)
					report("new_momentum_x", result.new_momentum_x, want.new_momentum_x);
				if (result.new_momentum_y !== want.new_momentum_y)
					report("new_momentum_y", result.new_momentum_y, want.new_momentum_y);
				if (result.new_momentum_z !== want.new_momentum_z)
					report("new_momentum_z", result.new_momentum_z, want.new_momentum_z);
				if (result.saturated !== want.saturated)
					report("saturated", 48'(result.saturated), 48'(want.saturated));
				if (want.saturated) clamped++;
			end
			checked++;
		end
	end

	// Receiver: random hold-offs, quiet stretches, and one long hold.
	initial begin
		int n;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			n = quiet_rx ? 0 : $urandom_range(0, 3);
			if (long_hold) begin
				n = 300;
				long_hold = 0;
			end
			repeat (n) begin
				result_stall <= 1'b1;
				@(posedge clk);
			end
			result_stall <= 1'b0;
			do @(posedge clk); while (!(result_valid && !result_stall));
		end
	end

	// Send one particle and queue its expected result.
	task automatic send(item_t x, bit typed, result_t typed_res, bit no_gap);
		int n;
		n = no_gap ? 0 : $urandom_range(0, 3);
		repeat (n) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item <= x;
		item_valid <= 1'b1;
		do @(posedge clk); while (item_stall);
		pending_momenta.push_back(typed ? typed_res : boris_rotate(x));
		pushed++;
	endtask

	task automatic write_coef(longint v);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= ADDR_HALF_STEP;
		pwdata <= 64'(v);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		coef = v;
		@(posedge clk);
	endtask

	task automatic drain();
		item_valid <= 1'b0;
		while (pending_momenta.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	// Random word: mostly moderate magnitudes, sometimes full range, extremes or values near zero.
	function automatic word_t rand_word();
		int k;
		k = $urandom_range(0, 9);
		if (k < 6) return word_t'(longint'($signed($urandom)) >>> $urandom_range(0, 8));
		if (k < 8) return word_t'({$urandom, $urandom});
		if (k == 8) return word_t'($urandom_range(0, 1) ? WMAX : WMIN);
		return word_t'(longint'($urandom_range(0, 3)) - 2);
	endfunction

	typedef struct {
		item_t x;
		bit typed;
		result_t want;
	} row_t;

	initial begin
		row_t rows[$];
		row_t r;
		item_t x;
		longint coefs[6];
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table under the reset coefficient of zero, where the
		// momentum passes through unless doubling it clamps.
		r.x = '0; r.typed = 1; r.want = '0; rows.push_back(r);
		r.x = '0; r.x.momentum_x = WORD_MAX; r.want = '0; r.want.saturated = 1;
		rows.push_back(r);
		r.x = '0; r.x.momentum_y = WORD_MIN; r.want = '0; r.want.saturated = 1;
		rows.push_back(r);
		r.x = '0; r.x.momentum_z = word_t'(ONE); r.want = '0;
		r.want.new_momentum_z = word_t'(ONE); rows.push_back(r);
		r.x = '{default: WORD_MAX}; r.typed = 0; rows.push_back(r);
		r.x = '{default: WORD_MIN}; rows.push_back(r);
		foreach (rows[i]) send(rows[i].x, rows[i].typed, rows[i].want, 0);
		drain();
		write_coef(ONE >>> 1);
		rows.delete();
		r.typed = 0;
		r.x = '{default: word_t'(ONE)}; rows.push_back(r);
		r.x = '{default: WORD_MAX}; rows.push_back(r);
		r.x = '{default: WORD_MIN}; rows.push_back(r);
		r.x = '0; r.x.magnetic_z = word_t'(ONE <<< 2); r.x.momentum_x = word_t'(ONE);
		rows.push_back(r);
		r.x = '0; r.x.electric_y = word_t'(-ONE); rows.push_back(r);
		r.x = '0; r.x.magnetic_x = WORD_MAX; r.x.momentum_y = word_t'(ONE <<< 10);
		rows.push_back(r);
		r.x = '{default: word_t'(-1)}; rows.push_back(r);
		foreach (rows[i]) send(rows[i].x, rows[i].typed, rows[i].want, 0);
		drain();

		// Random phases, one coefficient each, extremes included.
		coefs[0] = ONE >>> 4;
		coefs[1] = -(ONE >>> 2);
		coefs[2] = WMAX;
		coefs[3] = WMIN;
		coefs[4] = longint'($signed($urandom)) >>> 6;
		coefs[5] = 3;
		foreach (coefs[ph]) begin
			write_coef(coefs[ph]);
			quiet_rx = (ph == 1);
			if (ph == 2) long_hold = 1;
			for (int i = 0; i < 230; i++) begin
				x.momentum_x = rand_word();
				x.momentum_y = rand_word();
				x.momentum_z = rand_word();
				x.electric_x = rand_word();
				x.electric_y = rand_word();
				x.electric_z = rand_word();
				x.magnetic_x = rand_word();
				x.magnetic_y = rand_word();
				x.magnetic_z = rand_word();
				send(x, 0, '0, ph == 1 || ph == 2);
			end
			drain();
		end

		$display("covered %0d particles over 8 coefficient settings, %0d with a clamp",
			pushed, clamped);
		if (errors == 0 && pending_momenta.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/bmp_pkg.sv
rtl/bmp_mul.sv
rtl/bmp_rsqrt.sv
rtl/bmp_recip.sv
rtl/boris_momentum_push.sv
tb/boris_momentum_push_test.sv
